// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module
// Clocked on i_clk; the checker must provide i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define RDN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rdn checker: property failed");

// Check a property that also holds through reset.
`define RDN_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("rdn checker: reset property failed");

`endif

// ===== design/rdn_pkg.sv =====
// ----------------------------------------------------------------------------
// rdn_pkg
// Widths, types and constants of the ray direction normaliser.
// ----------------------------------------------------------------------------
package rdn_pkg;

    localparam int IN_WIDTH     = 24;
    localparam int FRAC_BITS    = 16;
    localparam int OUT_WIDTH    = FRAC_BITS + 2;
    localparam int SQ_WIDTH     = 2 * IN_WIDTH;
    // Holds the scaled squared magnitude and every partial term of the root.
    localparam int ACC_WIDTH    = 2 * IN_WIDTH + 2 * FRAC_BITS + 5;
    localparam int ROOT_STEPS   = FRAC_BITS + 1;
    localparam int FRONT_STAGES = 3;
    localparam int N_LANES      = 3;
    localparam int N_STAGES     = FRONT_STAGES + ROOT_STEPS + 1;

    // 1.0 and 0.0 in output fixed point
    localparam logic [OUT_WIDTH-1:0] UNIT_ONE  = OUT_WIDTH'(1) << FRAC_BITS;
    localparam logic [OUT_WIDTH-1:0] UNIT_ZERO = '0;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] d;   // remaining headroom
        logic signed [ACC_WIDTH-1:0] pb;  // scaled cross term
        logic [FRAC_BITS:0]          r;   // rounded quotient so far
        logic                        neg;
    } t_lane;

    typedef struct packed {
        t_lane [N_LANES-1:0]  lane;
        logic [ACC_WIDTH-1:0] q;          // scaled sum of squares
        logic                 zero;
        logic                 last;
    } t_root;

endpackage

// ===== design/rdn_if.sv =====
// ----------------------------------------------------------------------------
// rdn_in_if / rdn_out_if
// Valid/ready channels carrying ray directions and unit vectors.
// ----------------------------------------------------------------------------
interface rdn_in_if import rdn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IN_WIDTH-1:0]  dir_x;
    logic [IN_WIDTH-1:0]  dir_y;
    logic [IN_WIDTH-1:0]  dir_z;
    logic                 last_ray;

    modport source (output valid, dir_x, dir_y, dir_z, last_ray, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, last_ray, output ready);
endinterface

interface rdn_out_if import rdn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_WIDTH-1:0] unit_x;
    logic [OUT_WIDTH-1:0] unit_y;
    logic [OUT_WIDTH-1:0] unit_z;
    logic                 last_out;

    modport source (output valid, unit_x, unit_y, unit_z, last_out, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, last_out, output ready);
endinterface

// ===== design/ray_direction_normalizer_core.sv =====
// Pipeline: 3 set-up stages, 17 quotient stages and 1 output register lie
//   between an accepted transaction and its result.
// Throughput: one transaction per cycle while the output is not stalled; the
//   17-stage quotient pipeline holds up to 17 rays in flight.
// Reset: synchronous, active low; clears every stage valid bit.
// ----------------------------------------------------------------------------
// ray_direction_normalizer_core
// Turns a signed integer ray direction into a unit vector with 16 fraction
// bits, each component rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module ray_direction_normalizer_core import rdn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdn_in_if.sink    i_in,
    rdn_out_if.source o_out
);

    // Stage valid bits travel alongside the data; each stage advances when it
    // is empty or when the stage below advances, so bubbles are squeezed out.
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_en;
    t_root               w_root [ROOT_STEPS+1];

    logic [OUT_WIDTH-1:0] r_unit_x, r_unit_y, r_unit_z;
    logic [OUT_WIDTH-1:0] n_unit [N_LANES];
    logic                 r_last;

    always_comb begin
        w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || o_out.ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Magnitudes, squares and set-up of the quotient recurrence
    rdn_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[FRONT_STAGES-1:0]),
        .i_dir  ({i_in.dir_z, i_in.dir_y, i_in.dir_x}),
        .i_last (i_in.last_ray),
        .o_root (w_root[0])
    );

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        rdn_root_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (w_en[FRONT_STAGES+j]),
            .i_root (w_root[j]),
            .o_root (w_root[j+1])
        );
    end

    // Restore signs; a zero-length ray maps to +z
    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            n_unit[i] = w_root[ROOT_STEPS].lane[i].neg
                      ? OUT_WIDTH'(~OUT_WIDTH'(w_root[ROOT_STEPS].lane[i].r) + 1'b1)
                      : OUT_WIDTH'(w_root[ROOT_STEPS].lane[i].r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[N_STAGES-1]) begin
            r_unit_x <= w_root[ROOT_STEPS].zero ? UNIT_ZERO : n_unit[0];
            r_unit_y <= w_root[ROOT_STEPS].zero ? UNIT_ZERO : n_unit[1];
            r_unit_z <= w_root[ROOT_STEPS].zero ? UNIT_ONE  : n_unit[2];
            r_last   <= w_root[ROOT_STEPS].last;
        end
    end

    assign o_out.valid    = r_vld[N_STAGES-1];
    assign o_out.unit_x   = r_unit_x;
    assign o_out.unit_y   = r_unit_y;
    assign o_out.unit_z   = r_unit_z;
    assign o_out.last_out = r_last;

endmodule

// ===== design/rdn_front.sv =====
// ----------------------------------------------------------------------------
// rdn_front
// Magnitudes, squares and root set-up: three register stages.
// ----------------------------------------------------------------------------
module rdn_front import rdn_pkg::*; (
    input  logic                              i_clk,
    input  logic [FRONT_STAGES-1:0]           i_en,
    input  logic [N_LANES-1:0][IN_WIDTH-1:0]  i_dir,
    input  logic                              i_last,
    output t_root                             o_root
);

    logic [N_LANES-1:0][IN_WIDTH-1:0] r_mag, n_mag;
    logic [N_LANES-1:0]               r_neg_a, n_neg_a, r_neg_b;
    logic [N_LANES-1:0][SQ_WIDTH-1:0] r_sq, n_sq;
    logic                             r_last_a, r_last_b;
    t_root                            r_root, n_root;
    logic [SQ_WIDTH-1:0]              w_sum;
    logic [ACC_WIDTH-1:0]             w_sum_ext;

    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            n_neg_a[i] = i_dir[i][IN_WIDTH-1];
            n_mag[i]   = n_neg_a[i] ? IN_WIDTH'(~i_dir[i] + 1'b1) : i_dir[i];
            n_sq[i]    = {{IN_WIDTH{1'b0}}, r_mag[i]} * {{IN_WIDTH{1'b0}}, r_mag[i]};
        end
    end

    // Root set-up: d = m^2 * 4^(F+1) - S, pb = -S * 2^(F+2), q = S * 4^(F+1)
    always_comb begin
        w_sum     = r_sq[0] + r_sq[1] + r_sq[2];
        w_sum_ext = ACC_WIDTH'(w_sum);
        for (int i = 0; i < N_LANES; i++) begin
            n_root.lane[i].d   = (ACC_WIDTH'(r_sq[i]) << (2 * FRAC_BITS + 2)) - w_sum_ext;
            n_root.lane[i].pb  = '0 - (w_sum_ext << (FRAC_BITS + 2));
            n_root.lane[i].r   = '0;
            n_root.lane[i].neg = r_neg_b[i];
        end
        n_root.q    = w_sum_ext << (2 * FRAC_BITS + 2);
        n_root.zero = (w_sum == '0);
        n_root.last = r_last_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mag    <= n_mag;
            r_neg_a  <= n_neg_a;
            r_last_a <= i_last;
        end
        if (i_en[1]) begin
            r_sq     <= n_sq;
            r_neg_b  <= r_neg_a;
            r_last_b <= r_last_a;
        end
        if (i_en[2]) begin
            r_root   <= n_root;
        end
    end

    assign o_root = r_root;

endmodule

// ===== design/rdn_root_stage.sv =====
// ----------------------------------------------------------------------------
// rdn_root_stage
// One bit of the rounded quotient m * 2^F / sqrt(S) for all three lanes.
// ----------------------------------------------------------------------------
module rdn_root_stage import rdn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_root i_root,
    output t_root o_root
);

    t_root                       r_root, n_root;
    logic signed [ACC_WIDTH-1:0] w_delta [N_LANES];
    logic signed [ACC_WIDTH-1:0] w_pb    [N_LANES];
    logic [N_LANES-1:0]          w_take;

    // Take the bit when the odd square (2c-1)^2 * S still fits under m^2 * 4^(F+1)
    always_comb begin
        n_root = i_root;
        for (int i = 0; i < N_LANES; i++) begin
            w_delta[i] = i_root.lane[i].pb + $signed(i_root.q);
            w_take[i]  = (i_root.lane[i].d >= w_delta[i]);
            w_pb[i]    = w_take[i] ? i_root.lane[i].pb + $signed(i_root.q << 1)
                                   : i_root.lane[i].pb;
            n_root.lane[i].d  = w_take[i] ? i_root.lane[i].d - w_delta[i]
                                          : i_root.lane[i].d;
            n_root.lane[i].pb = w_pb[i] >>> 1;
            n_root.lane[i].r  = {i_root.lane[i].r[FRAC_BITS-1:0], w_take[i]};
        end
        n_root.q = i_root.q >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
        end
    end

    assign o_root = r_root;

endmodule

// ===== design/rdn_checker.sv =====
// ----------------------------------------------------------------------------
// rdn_checker
// Port-level checks of the ray direction normaliser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdn_checker import rdn_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [OUT_WIDTH-1:0] i_unit_x,
    input logic [OUT_WIDTH-1:0] i_unit_y,
    input logic [OUT_WIDTH-1:0] i_unit_z,
    input logic                 i_last_out
);

    // A pending result stays offered
    `RDN_ASSERT(a_valid_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    // and its payload does not move
    `RDN_ASSERT(a_data_hold, i_out_valid && !i_out_ready |=> $stable(i_unit_x) && $stable(i_unit_y) && $stable(i_unit_z) && $stable(i_last_out))
    // Reset empties the pipeline
    `RDN_ASSERT_RST(a_reset_empty, !i_rst_n |=> !i_out_valid)
    // A result on the z axis has unit length
    `RDN_ASSERT(a_z_axis, i_out_valid && i_unit_x == UNIT_ZERO && i_unit_y == UNIT_ZERO |-> i_unit_z == UNIT_ONE || i_unit_z == OUT_WIDTH'(~UNIT_ONE + 1'b1))

endmodule

bind ray_direction_normalizer_core rdn_checker u_rdn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_unit_x    (o_out.unit_x),
    .i_unit_y    (o_out.unit_y),
    .i_unit_z    (o_out.unit_z),
    .i_last_out  (o_out.last_out)
);

// ===== tb/tb_ray_direction_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_ray_direction_normalizer_core
// Drives ray directions through the normaliser with random gaps and stalls,
// predicts each unit vector by an exact integer square-root comparison (or takes
// a hand-typed result from the directed table) and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_ray_direction_normalizer_core;
    import rdn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IN_WIDTH-1:0]  x;
        logic [IN_WIDTH-1:0]  y;
        logic [IN_WIDTH-1:0]  z;
        logic                 last;
    } t_ray;

    typedef struct {
        logic [OUT_WIDTH-1:0] ux;
        logic [OUT_WIDTH-1:0] uy;
        logic [OUT_WIDTH-1:0] uz;
        logic                 last;
    } t_unit;

    // One row of the directed table; has_fixed marks a hand-typed result.
    typedef struct {
        t_ray  ray;
        bit    has_fixed;
        t_unit fixed;
    } t_row;

    localparam int N_RANDOM  = 1530;
    localparam int MAX_CYCLE = 400000;
    localparam logic [IN_WIDTH-1:0] MAXP = {1'b0, {(IN_WIDTH-1){1'b1}}};
    localparam logic [IN_WIDTH-1:0] MAXN = {1'b1, {(IN_WIDTH-1){1'b0}}};
    localparam logic [IN_WIDTH-1:0] ONE  = IN_WIDTH'(1);
    localparam logic [IN_WIDTH-1:0] MONE = '1;
    localparam logic [OUT_WIDTH-1:0] NEG_ONE = -UNIT_ONE;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   failed = 1'b0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;
    int   cycle = 0;
    int   n_sent = 0;

    t_unit unit_queue[$];

    rdn_in_if  in_ch();
    rdn_out_if out_ch();

    ray_direction_normalizer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // Magnitude of a two's complement field; the most negative value keeps
    // its true size because the result is one bit wider.
    function automatic logic [IN_WIDTH:0] magnitude(logic [IN_WIDTH-1:0] v);
        logic [IN_WIDTH:0] w;
        w = {v[IN_WIDTH-1], v};
        return v[IN_WIDTH-1] ? -w : w;
    endfunction

    // Largest r with (2r-1)^2 * sumsq <= (mag * 2^(F+1))^2: round to nearest,
    // ties away from zero, of mag * 2^F / sqrt(sumsq).
    function automatic logic [FRAC_BITS:0] rounded_quotient(
        logic [IN_WIDTH:0] mag, logic [127:0] sumsq);
        logic [FRAC_BITS:0] r;
        logic [FRAC_BITS:0] c;
        logic [255:0]       lhs;
        logic [255:0]       rhs;
        r = '0;
        rhs = (256'(mag) * 256'(mag)) << (2 * FRAC_BITS + 2);
        for (int b = FRAC_BITS; b >= 0; b--) begin
            c = r | ((FRAC_BITS+1)'(1) << b);
            lhs = (256'(2 * c) - 1) * (256'(2 * c) - 1) * 256'(sumsq);
            if (lhs <= rhs) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic t_unit normalise(t_ray ray);
        logic [IN_WIDTH:0]    m[3];
        logic [IN_WIDTH-1:0]  v[3];
        logic [OUT_WIDTH-1:0] o[3];
        logic [127:0]         sumsq;
        t_unit                u;
        v[0] = ray.x;
        v[1] = ray.y;
        v[2] = ray.z;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            sumsq += 128'(m[i]) * 128'(m[i]);
        end
        for (int i = 0; i < 3; i++) begin
            o[i] = OUT_WIDTH'(rounded_quotient(m[i], sumsq));
            if (v[i][IN_WIDTH-1]) begin
                o[i] = -o[i];
            end
        end
        if (sumsq == 0) begin
            o[0] = UNIT_ZERO;
            o[1] = UNIT_ZERO;
            o[2] = UNIT_ONE;
        end
        u.ux = o[0];
        u.uy = o[1];
        u.uz = o[2];
        u.last = ray.last;
        return u;
    endfunction

    function automatic t_row row(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y,
                                 logic [IN_WIDTH-1:0] z, logic last, bit has_fixed,
                                 logic [OUT_WIDTH-1:0] ux, logic [OUT_WIDTH-1:0] uy,
                                 logic [OUT_WIDTH-1:0] uz);
        t_row r;
        r.ray = '{x, y, z, last};
        r.has_fixed = has_fixed;
        r.fixed = '{ux, uy, uz, last};
        return r;
    endfunction

    // Bias components so that large, small, single-axis and tie-prone shapes
    // all appear, with every bit of each field toggling.
    function automatic logic [IN_WIDTH-1:0] random_component();
        case ($urandom_range(0, 5))
            0: return IN_WIDTH'($urandom);
            1: return IN_WIDTH'($signed($urandom_range(0, 8)) - 4);
            2: return $urandom_range(0, 1) ? MAXP : MAXN;
            3: return '0;
            4: return IN_WIDTH'($urandom) >> $urandom_range(0, IN_WIDTH - 1);
            default: return -(IN_WIDTH'($urandom) >> $urandom_range(0, IN_WIDTH - 1));
        endcase
    endfunction

    // Hold a transaction on the input channel until it is accepted.
    task automatic send_ray(t_ray ray);
        in_ch.valid    <= 1'b1;
        in_ch.dir_x    <= ray.x;
        in_ch.dir_y    <= ray.y;
        in_ch.dir_z    <= ray.z;
        in_ch.last_ray <= ray.last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic offer(t_ray ray, t_unit want);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        send_ray(ray);
        unit_queue.push_back(want);
    endtask

    // Stimulus: directed table first, then random rays.
    initial begin
        t_row rows[$];
        t_ray ray;
        in_ch.valid    = 1'b0;
        in_ch.dir_x    = '0;
        in_ch.dir_y    = '0;
        in_ch.dir_z    = '0;
        in_ch.last_ray = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector, single axes, most negative value at true magnitude
        rows.push_back(row('0, '0, '0, 1'b0, 1, UNIT_ZERO, UNIT_ZERO, UNIT_ONE));
        rows.push_back(row('0, '0, '0, 1'b1, 1, UNIT_ZERO, UNIT_ZERO, UNIT_ONE));
        rows.push_back(row(ONE, '0, '0, 1'b0, 1, UNIT_ONE, UNIT_ZERO, UNIT_ZERO));
        rows.push_back(row('0, MONE, '0, 1'b1, 1, UNIT_ZERO, NEG_ONE, UNIT_ZERO));
        rows.push_back(row('0, '0, MAXP, 1'b0, 1, UNIT_ZERO, UNIT_ZERO, UNIT_ONE));
        rows.push_back(row(MAXN, '0, '0, 1'b0, 1, NEG_ONE, UNIT_ZERO, UNIT_ZERO));
        rows.push_back(row('0, MAXN, '0, 1'b1, 1, UNIT_ZERO, NEG_ONE, UNIT_ZERO));
        rows.push_back(row('0, '0, MAXN, 1'b0, 1, UNIT_ZERO, UNIT_ZERO, NEG_ONE));
        // mixed extremes and small vectors, checked by the predictor
        rows.push_back(row(MAXN, MAXN, MAXN, 1'b1, 0, '0, '0, '0));
        rows.push_back(row(MAXP, MAXP, MAXP, 1'b0, 0, '0, '0, '0));
        rows.push_back(row(MAXP, MAXN, MAXP, 1'b0, 0, '0, '0, '0));
        rows.push_back(row(MAXN, ONE, '0, 1'b0, 0, '0, '0, '0));
        rows.push_back(row(ONE, ONE, ONE, 1'b0, 0, '0, '0, '0));
        rows.push_back(row(MONE, ONE, MONE, 1'b1, 0, '0, '0, '0));
        rows.push_back(row(IN_WIDTH'(3), IN_WIDTH'(4), '0, 1'b0, 0, '0, '0, '0));
        rows.push_back(row(-IN_WIDTH'(3), '0, -IN_WIDTH'(4), 1'b0, 0, '0, '0, '0));
        rows.push_back(row(IN_WIDTH'(2), IN_WIDTH'(1), IN_WIDTH'(2), 1'b0, 0, '0, '0, '0));
        rows.push_back(row(ONE, ONE, '0, 1'b0, 0, '0, '0, '0));
        rows.push_back(row(MAXP, ONE, MONE, 1'b1, 0, '0, '0, '0));

        foreach (rows[i]) begin
            offer(rows[i].ray, rows[i].has_fixed ? rows[i].fixed : normalise(rows[i].ray));
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            ray.x = random_component();
            ray.y = random_component();
            ray.z = random_component();
            ray.last = 1'($urandom_range(0, 1));
            // a back-to-back burst around the long hold-off fills the pipeline
            if (n >= 400 && n < 500) begin
                send_ray(ray);
                unit_queue.push_back(normalise(ray));
            end else begin
                offer(ray, normalise(ray));
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!out_ch.valid);
        end
    end

    // Start the long hold-off once, during the back-to-back burst.
    initial begin
        @(posedge i_rst_n);
        wait (n_sent > 430);
        hold_off = 1'b1;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_unit want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (unit_queue.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h last=%b", $realtime,
                         out_ch.unit_x, out_ch.unit_y, out_ch.unit_z, out_ch.last_out);
                failed = 1'b1;
            end else begin
                want = unit_queue.pop_front();
                if (out_ch.unit_x !== want.ux) begin
                    $display("%0t: unit_x expected %h actual %h", $realtime, want.ux,
                             out_ch.unit_x);
                    failed = 1'b1;
                end
                if (out_ch.unit_y !== want.uy) begin
                    $display("%0t: unit_y expected %h actual %h", $realtime, want.uy,
                             out_ch.unit_y);
                    failed = 1'b1;
                end
                if (out_ch.unit_z !== want.uz) begin
                    $display("%0t: unit_z expected %h actual %h", $realtime, want.uz,
                             out_ch.unit_z);
                    failed = 1'b1;
                end
                if (out_ch.last_out !== want.last) begin
                    $display("%0t: last_out expected %b actual %b", $realtime, want.last,
                             out_ch.last_out);
                    failed = 1'b1;
                end
            end
        end
    end

    // End of run: drain, let the pipeline settle, then report.
    initial begin
        wait (stim_done && unit_queue.size() == 0);
        repeat (40) @(posedge i_clk);
        if (!failed && unit_queue.size() == 0) begin
            $display("ray_direction_normalizer_core: match");
        end else begin
            $display("ray_direction_normalizer_core: mismatch");
        end
        $finish;
    end

    // Advance the cycle counter and stop a hung run.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle == MAX_CYCLE) begin
            $display("ray_direction_normalizer_core: mismatch");
            $finish;
        end
    end
endmodule

// ===== files.f =====
+incdir+design
design/rdn_pkg.sv
design/rdn_if.sv
design/rdn_front.sv
design/rdn_root_stage.sv
design/ray_direction_normalizer_core.sv
design/rdn_checker.sv
tb/tb_ray_direction_normalizer_core.sv
